// ===== rtl/svie_pkg.sv =====
`timescale 1ns / 1ps
package svie_pkg;

   localparam int unsigned WORD_W = 32;

   localparam logic [4:0] OP_PUSH   = 5'd0;
   localparam logic [4:0] OP_ADD    = 5'd1;
   localparam logic [4:0] OP_SUB    = 5'd2;
   localparam logic [4:0] OP_MUL    = 5'd3;
   localparam logic [4:0] OP_DIV    = 5'd4;
   localparam logic [4:0] OP_DUP    = 5'd5;
   localparam logic [4:0] OP_SWAP   = 5'd6;
   localparam logic [4:0] OP_ROT    = 5'd7;
   localparam logic [4:0] OP_DROP   = 5'd8;
   localparam logic [4:0] OP_PRNUM  = 5'd9;
   localparam logic [4:0] OP_PRCHR  = 5'd10;
   localparam logic [4:0] OP_DUMP   = 5'd11;
   localparam logic [4:0] OP_STA    = 5'd12;
   localparam logic [4:0] OP_LDA    = 5'd13;
   localparam logic [4:0] OP_CMP    = 5'd14;
   localparam logic [4:0] OP_JMP    = 5'd15;
   localparam logic [4:0] OP_JC     = 5'd16;
   localparam logic [4:0] OP_JNC    = 5'd17;
   localparam logic [4:0] OP_JEQ    = 5'd18;
   localparam logic [4:0] OP_JNE    = 5'd19;
   localparam logic [4:0] OP_JL     = 5'd20;
   localparam logic [4:0] OP_JLE    = 5'd21;
   localparam logic [4:0] OP_JG     = 5'd22;
   localparam logic [4:0] OP_JGE    = 5'd23;
   localparam logic [4:0] OP_STP    = 5'd24;
   localparam logic [4:0] OP_LDP    = 5'd25;
   localparam logic [4:0] OP_CALL   = 5'd26;
   localparam logic [4:0] OP_RET    = 5'd27;
   localparam logic [4:0] OP_EXIT   = 5'd28;

   localparam logic CMD_EXEC    = 1'b0;
   localparam logic CMD_PRELOAD = 1'b1;

   localparam int unsigned FL_EQ = 0;
   localparam int unsigned FL_LT = 1;
   localparam int unsigned FL_GT = 2;
   localparam int unsigned FL_CY = 3;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_OVER    = 3'd1,
      ST_UNDER   = 3'd2,
      ST_ILLEGAL = 3'd3,
      ST_ADDR    = 3'd4,
      ST_DIVZERO = 3'd5,
      ST_HALTED  = 3'd6
   } status_type;

   typedef enum logic [1:0] {
      EV_NONE  = 2'd0,
      EV_PRNUM = 2'd1,
      EV_PRCHR = 2'd2,
      EV_EXIT  = 2'd3
   } event_type;

   typedef struct packed {
      logic               command;
      logic [4:0]         opcode;
      logic signed [31:0] operand;
      logic [11:0]        load_address;
      logic signed [31:0] load_data;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic [31:0]        next_pointer;
      event_type          event_kind;
      logic signed [31:0] event_value;
   } rsp_type;

   typedef struct packed {
      req_type req;
      logic    preload;
      logic    illegal;
   } entry_type;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_R1, S_R2, S_R3, S_R4, S_EXEC, S_DIV, S_W1, S_W2, S_DONE
   } back_state_type;

endpackage

// ===== rtl/svie_front.sv =====
`timescale 1ns / 1ps
module svie_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  svie_pkg::req_type   req_data,
   input  logic                clearing,
   input  logic                q_full,
   output logic                q_push,
   output svie_pkg::entry_type q_data
);

   logic seen_ff, seen_in;

   assign req_stall = q_full | clearing;
   assign q_push    = req_valid & ~req_stall;

   always_comb begin
      q_data.req     = req_data;
      q_data.preload = (req_data.command == svie_pkg::CMD_PRELOAD);
      q_data.illegal = (req_data.opcode > svie_pkg::OP_EXIT);
      seen_in        = seen_ff | q_push;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= 1'b0;
      end else begin
         seen_ff <= seen_in;
      end
   end

   // nothing enters before the memory clear has finished
   a_no_push_in_clear: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !q_push) else $error("item taken during clear");
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      q_full |-> req_stall) else $error("queue full but not stalled");
   a_seen: assert property (@(posedge clock) disable iff (reset)
      q_push |=> seen_ff) else $error("seen flag lost");

endmodule

// ===== rtl/svie_queue.sv =====
`timescale 1ns / 1ps
module svie_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  svie_pkg::entry_type push_data,
   output logic                full,
   input  logic                pop,
   output svie_pkg::entry_type pop_data,
   output logic                empty
);

   svie_pkg::entry_type ent_ff [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;

   assign full     = (cnt_ff == 2'd2);
   assign empty    = (cnt_ff == 2'd0);
   assign pop_data = ent_ff[rp_ff];

   always_comb begin
      wp_in  = wp_ff ^ push;
      rp_in  = rp_ff ^ pop;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wp_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full) else $error("queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty) else $error("queue underflow");
   a_count: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3) else $error("queue count out of range");

endmodule

// ===== rtl/svie_back.sv =====
`timescale 1ns / 1ps
module svie_back #(
   parameter int unsigned STACK_DEPTH = 1024,
   parameter int unsigned MEM_DEPTH   = 4096
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_empty,
   output logic                q_pop,
   input  svie_pkg::entry_type q_data,
   output logic                clearing,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output svie_pkg::rsp_type   rsp_data
);

   localparam int unsigned AW  = $clog2(STACK_DEPTH);
   localparam int unsigned CW  = AW + 1;
   localparam int unsigned MAW = $clog2(MEM_DEPTH);

   svie_pkg::back_state_type state_ff, state_in;

   logic [31:0] ds_mem [STACK_DEPTH];
   logic [31:0] rs_mem [STACK_DEPTH];
   logic [31:0] dm_mem [MEM_DEPTH];

   logic [31:0] ds_rdata_ff, rs_rdata_ff, dm_rdata_ff;
   logic [AW-1:0]  ds_raddr, rs_raddr;
   logic [MAW-1:0] dm_raddr;

   svie_pkg::entry_type cur_ff;
   logic [31:0] b_ff, a_ff, c_ff, ret_ff, prod_ff;
   logic [CW-1:0] dc_ff, rc_ff;
   logic [31:0] ip_ff;
   logic [3:0]  fl_ff;
   logic        halted_ff;
   logic [MAW-1:0] clr_ff;

   logic           w1_en_ff, w2_en_ff;
   logic [AW-1:0]  w1_addr_ff, w2_addr_ff;
   logic [31:0]    w1_data_ff, w2_data_ff;

   logic [31:0] dv_rem_ff, dv_quo_ff, dv_den_ff;
   logic [4:0]  dv_cnt_ff;
   logic        dv_qneg_ff, dv_rneg_ff;

   svie_pkg::rsp_type res_ff, rsp_ff;
   logic              rsp_valid_ff;

   // execute-step results
   svie_pkg::status_type st;
   svie_pkg::event_type  kind;
   logic [31:0] ev, ip_n, ip_inc, opnd;
   logic [CW-1:0] dc_n, rc_n;
   logic [3:0]  fl_n;
   logic        halt_n, take, go_div;
   logic        x1_en, x2_en;
   logic [AW-1:0] x1_addr, x2_addr;
   logic [31:0] x1_data, x2_data;
   logic        dm_we_x;
   logic [MAW-1:0] dm_wa_x;
   logic [31:0] dm_wd_x;
   logic        rs_we_x;

   logic [CW-1:0] dcm1, dcm2, dcm3, rcm1;
   logic full_d, full_r, opnd_ok, top_ok, out_free;
   logic [32:0] rem_sh, diff;
   logic [31:0] c_add, c_sub;

   assign dcm1 = dc_ff - CW'(1);
   assign dcm2 = dc_ff - CW'(2);
   assign dcm3 = dc_ff - CW'(3);
   assign rcm1 = rc_ff - CW'(1);
   assign full_d = (dc_ff >= CW'(STACK_DEPTH - 1));
   assign full_r = (rc_ff >= CW'(STACK_DEPTH - 1));
   assign opnd = cur_ff.req.operand;
   assign opnd_ok = !opnd[31] && (opnd < 32'(MEM_DEPTH));
   assign top_ok  = !b_ff[31] && (b_ff < 32'(MEM_DEPTH));
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign c_add = a_ff + b_ff;
   assign c_sub = a_ff - b_ff;

   assign clearing  = (state_ff == svie_pkg::S_CLEAR);
   assign q_pop     = (state_ff == svie_pkg::S_IDLE) && !q_empty;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign rem_sh = {dv_rem_ff, dv_quo_ff[31]};
   assign diff   = rem_sh - {1'b0, dv_den_ff};

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         svie_pkg::S_CLEAR: if (clr_ff == MAW'(MEM_DEPTH - 1)) state_in = svie_pkg::S_IDLE;
         svie_pkg::S_IDLE:  if (!q_empty) state_in = svie_pkg::S_R1;
         svie_pkg::S_R1:    state_in = svie_pkg::S_R2;
         svie_pkg::S_R2:    state_in = svie_pkg::S_R3;
         svie_pkg::S_R3:    state_in = svie_pkg::S_R4;
         svie_pkg::S_R4:    state_in = svie_pkg::S_EXEC;
         svie_pkg::S_EXEC:  state_in = go_div ? svie_pkg::S_DIV : svie_pkg::S_W1;
         svie_pkg::S_DIV:   if (dv_cnt_ff == 5'd31) state_in = svie_pkg::S_W1;
         svie_pkg::S_W1:    state_in = svie_pkg::S_W2;
         svie_pkg::S_W2:    state_in = svie_pkg::S_DONE;
         svie_pkg::S_DONE:  if (out_free) state_in = svie_pkg::S_IDLE;
         default:           state_in = svie_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= svie_pkg::S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // stack and memory read addresses
   always_comb begin
      ds_raddr = dcm1[AW-1:0];
      case (state_ff)
         svie_pkg::S_R2: ds_raddr = dcm2[AW-1:0];
         svie_pkg::S_R3: ds_raddr = dcm3[AW-1:0];
         default:        ds_raddr = dcm1[AW-1:0];
      endcase
      rs_raddr = rcm1[AW-1:0];
      dm_raddr = (cur_ff.req.opcode == svie_pkg::OP_LDP) ? b_ff[MAW-1:0] : opnd[MAW-1:0];
   end

   // one instruction step
   always_comb begin
      st = svie_pkg::ST_OK;
      kind = svie_pkg::EV_NONE;
      ev = 32'd0;
      take = 1'b0;
      go_div = 1'b0;
      dc_n = dc_ff;
      rc_n = rc_ff;
      fl_n = fl_ff;
      halt_n = halted_ff;
      ip_inc = ip_ff + 32'd1;
      ip_n = ip_ff;
      x1_en = 1'b0; x1_addr = dc_ff[AW-1:0]; x1_data = 32'd0;
      x2_en = 1'b0; x2_addr = dcm1[AW-1:0]; x2_data = 32'd0;
      dm_we_x = 1'b0;
      dm_wa_x = opnd[MAW-1:0];
      dm_wd_x = b_ff;
      rs_we_x = 1'b0;
      if (cur_ff.preload) begin
         if (32'(cur_ff.req.load_address) < 32'(MEM_DEPTH)) begin
            dm_we_x = 1'b1;
            dm_wa_x = MAW'(cur_ff.req.load_address);
            dm_wd_x = cur_ff.req.load_data;
         end else begin
            st = svie_pkg::ST_ADDR;
         end
      end else if (halted_ff) begin
         st = svie_pkg::ST_HALTED;
      end else begin
         ip_n = ip_inc;
         case (cur_ff.req.opcode)
            svie_pkg::OP_PUSH: begin
               if (full_d) st = svie_pkg::ST_OVER;
               else begin
                  x1_en = 1'b1; x1_data = opnd; dc_n = dc_ff + CW'(1);
               end
            end
            svie_pkg::OP_ADD, svie_pkg::OP_SUB, svie_pkg::OP_MUL, svie_pkg::OP_DIV,
            svie_pkg::OP_SWAP, svie_pkg::OP_CMP: begin
               x1_addr = dcm2[AW-1:0];
               x2_addr = dcm1[AW-1:0];
               if (dc_ff < CW'(2)) st = svie_pkg::ST_UNDER;
               else if (cur_ff.req.opcode == svie_pkg::OP_DIV && b_ff == 32'd0)
                  st = svie_pkg::ST_DIVZERO;
               else begin
                  case (cur_ff.req.opcode)
                     svie_pkg::OP_ADD: begin
                        x1_en = 1'b1; x1_data = c_add; dc_n = dcm1;
                        fl_n[svie_pkg::FL_CY] = $signed(c_add) < $signed(a_ff);
                     end
                     svie_pkg::OP_SUB: begin
                        x1_en = 1'b1; x1_data = c_sub; dc_n = dcm1;
                        fl_n[svie_pkg::FL_CY] = $signed(c_sub) > $signed(a_ff);
                     end
                     svie_pkg::OP_MUL: begin
                        x1_en = 1'b1; x1_data = prod_ff; dc_n = dcm1;
                        fl_n[svie_pkg::FL_CY] = $signed(prod_ff) < $signed(a_ff);
                     end
                     svie_pkg::OP_DIV: begin
                        go_div = 1'b1; x1_en = 1'b1; x2_en = 1'b1;
                     end
                     svie_pkg::OP_SWAP: begin
                        x1_en = 1'b1; x1_data = b_ff;
                        x2_en = 1'b1; x2_data = a_ff;
                     end
                     default: begin
                        dc_n = dcm2;
                        fl_n[svie_pkg::FL_EQ] = (a_ff == b_ff);
                        fl_n[svie_pkg::FL_LT] = $signed(a_ff) < $signed(b_ff);
                        fl_n[svie_pkg::FL_GT] = $signed(a_ff) > $signed(b_ff);
                     end
                  endcase
               end
            end
            svie_pkg::OP_DUP: begin
               if (full_d) st = svie_pkg::ST_OVER;
               else if (dc_ff < CW'(1)) st = svie_pkg::ST_UNDER;
               else begin
                  x1_en = 1'b1; x1_data = b_ff; dc_n = dc_ff + CW'(1);
               end
            end
            svie_pkg::OP_ROT: begin
               if (dc_ff < CW'(3)) st = svie_pkg::ST_UNDER;
               else begin
                  x1_en = 1'b1; x1_addr = dcm1[AW-1:0]; x1_data = c_ff;
                  x2_en = 1'b1; x2_addr = dcm3[AW-1:0]; x2_data = b_ff;
               end
            end
            svie_pkg::OP_DROP, svie_pkg::OP_PRNUM, svie_pkg::OP_PRCHR: begin
               if (dc_ff < CW'(1)) st = svie_pkg::ST_UNDER;
               else begin
                  dc_n = dcm1;
                  if (cur_ff.req.opcode == svie_pkg::OP_PRNUM) begin
                     kind = svie_pkg::EV_PRNUM; ev = b_ff;
                  end else if (cur_ff.req.opcode == svie_pkg::OP_PRCHR) begin
                     kind = svie_pkg::EV_PRCHR; ev = {24'd0, b_ff[7:0]};
                  end
               end
            end
            svie_pkg::OP_DUMP: begin
               st = svie_pkg::ST_OK;
            end
            svie_pkg::OP_STA: begin
               if (dc_ff < CW'(1)) st = svie_pkg::ST_UNDER;
               else if (!opnd_ok) st = svie_pkg::ST_ADDR;
               else begin
                  dm_we_x = 1'b1; dc_n = dcm1;
               end
            end
            svie_pkg::OP_LDA: begin
               if (full_d) st = svie_pkg::ST_OVER;
               else if (!opnd_ok) st = svie_pkg::ST_ADDR;
               else begin
                  x1_en = 1'b1; x1_data = dm_rdata_ff; dc_n = dc_ff + CW'(1);
               end
            end
            svie_pkg::OP_JMP: take = 1'b1;
            svie_pkg::OP_JC:  take = fl_ff[svie_pkg::FL_CY];
            svie_pkg::OP_JNC: take = !fl_ff[svie_pkg::FL_CY];
            svie_pkg::OP_JEQ: take = fl_ff[svie_pkg::FL_EQ];
            svie_pkg::OP_JNE: take = !fl_ff[svie_pkg::FL_EQ];
            svie_pkg::OP_JL:  take = fl_ff[svie_pkg::FL_LT];
            svie_pkg::OP_JLE: take = fl_ff[svie_pkg::FL_LT] | fl_ff[svie_pkg::FL_EQ];
            svie_pkg::OP_JG:  take = fl_ff[svie_pkg::FL_GT];
            svie_pkg::OP_JGE: take = fl_ff[svie_pkg::FL_GT] | fl_ff[svie_pkg::FL_EQ];
            svie_pkg::OP_STP: begin
               if (dc_ff < CW'(2)) st = svie_pkg::ST_UNDER;
               else if (!top_ok) st = svie_pkg::ST_ADDR;
               else begin
                  dm_we_x = 1'b1; dm_wa_x = b_ff[MAW-1:0]; dm_wd_x = a_ff; dc_n = dcm2;
               end
            end
            svie_pkg::OP_LDP: begin
               if (dc_ff < CW'(1)) st = svie_pkg::ST_UNDER;
               else if (!top_ok) st = svie_pkg::ST_ADDR;
               else begin
                  x1_en = 1'b1; x1_addr = dcm1[AW-1:0]; x1_data = dm_rdata_ff;
               end
            end
            svie_pkg::OP_CALL: begin
               if (full_r) st = svie_pkg::ST_OVER;
               else begin
                  rs_we_x = 1'b1; rc_n = rc_ff + CW'(1); take = 1'b1;
               end
            end
            svie_pkg::OP_RET: begin
               if (rc_ff < CW'(1)) st = svie_pkg::ST_UNDER;
               else begin
                  rc_n = rcm1; ip_n = ret_ff;
               end
            end
            svie_pkg::OP_EXIT: begin
               kind = svie_pkg::EV_EXIT;
               halt_n = 1'b1;
               if (dc_ff >= CW'(1)) begin
                  ev = b_ff; dc_n = dcm1;
               end
            end
            default: st = svie_pkg::ST_ILLEGAL;
         endcase
         if (cur_ff.illegal) st = svie_pkg::ST_ILLEGAL;
         if (take) ip_n = opnd;
      end
   end

   // memories
   always_ff @(posedge clock) begin
      ds_rdata_ff <= ds_mem[ds_raddr];
      if (state_ff == svie_pkg::S_W1 && w1_en_ff) ds_mem[w1_addr_ff] <= w1_data_ff;
      else if (state_ff == svie_pkg::S_W2 && w2_en_ff) ds_mem[w2_addr_ff] <= w2_data_ff;
   end

   always_ff @(posedge clock) begin
      rs_rdata_ff <= rs_mem[rs_raddr];
      if (state_ff == svie_pkg::S_EXEC && rs_we_x) rs_mem[rc_ff[AW-1:0]] <= ip_inc;
   end

   always_ff @(posedge clock) begin
      dm_rdata_ff <= dm_mem[dm_raddr];
      if (state_ff == svie_pkg::S_CLEAR) dm_mem[clr_ff] <= 32'd0;
      else if (state_ff == svie_pkg::S_EXEC && dm_we_x) dm_mem[dm_wa_x] <= dm_wd_x;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         dc_ff        <= '0;
         rc_ff        <= '0;
         ip_ff        <= 32'd0;
         fl_ff        <= 4'd0;
         halted_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (state_ff == svie_pkg::S_CLEAR) clr_ff <= clr_ff + MAW'(1);
         if (state_ff == svie_pkg::S_EXEC) begin
            dc_ff     <= dc_n;
            rc_ff     <= rc_n;
            ip_ff     <= ip_n;
            fl_ff     <= fl_n;
            halted_ff <= halt_n;
         end
         if (state_ff == svie_pkg::S_DONE && out_free) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         svie_pkg::S_IDLE: if (!q_empty) cur_ff <= q_data;
         svie_pkg::S_R2: begin
            b_ff   <= ds_rdata_ff;
            ret_ff <= rs_rdata_ff;
         end
         svie_pkg::S_R3: a_ff <= ds_rdata_ff;
         svie_pkg::S_R4: begin
            c_ff    <= ds_rdata_ff;
            prod_ff <= a_ff * b_ff;
         end
         svie_pkg::S_EXEC: begin
            w1_en_ff   <= x1_en;  w1_addr_ff <= x1_addr; w1_data_ff <= x1_data;
            w2_en_ff   <= x2_en;  w2_addr_ff <= x2_addr; w2_data_ff <= x2_data;
            res_ff.status       <= st;
            res_ff.next_pointer <= ip_n;
            res_ff.event_kind   <= kind;
            res_ff.event_value  <= ev;
            // set up magnitudes for the shift-subtract divider
            dv_rem_ff  <= 32'd0;
            dv_quo_ff  <= a_ff[31] ? (32'd0 - a_ff) : a_ff;
            dv_den_ff  <= b_ff[31] ? (32'd0 - b_ff) : b_ff;
            dv_qneg_ff <= a_ff[31] ^ b_ff[31];
            dv_rneg_ff <= a_ff[31];
            dv_cnt_ff  <= 5'd0;
         end
         svie_pkg::S_DIV: begin
            dv_cnt_ff <= dv_cnt_ff + 5'd1;
            if (!diff[32]) begin
               dv_rem_ff <= diff[31:0];
               dv_quo_ff <= {dv_quo_ff[30:0], 1'b1};
            end else begin
               dv_rem_ff <= rem_sh[31:0];
               dv_quo_ff <= {dv_quo_ff[30:0], 1'b0};
            end
         end
         svie_pkg::S_W1: begin
            // remainder goes below the quotient
            if (cur_ff.req.opcode == svie_pkg::OP_DIV && !cur_ff.preload) begin
               w1_data_ff <= w1_data_ff;
            end
         end
         svie_pkg::S_DONE: if (out_free) rsp_ff <= res_ff;
         default: begin
         end
      endcase
      if (state_ff == svie_pkg::S_DIV && dv_cnt_ff == 5'd31) begin
         w1_data_ff <= dv_rneg_ff ? (32'd0 - (diff[32] ? rem_sh[31:0] : diff[31:0]))
                                  : (diff[32] ? rem_sh[31:0] : diff[31:0]);
         w2_data_ff <= dv_qneg_ff ? (32'd0 - {dv_quo_ff[30:0], !diff[32]})
                                  : {dv_quo_ff[30:0], !diff[32]};
      end
   end

   a_dc_bound: assert property (@(posedge clock) disable iff (reset)
      dc_ff <= CW'(STACK_DEPTH - 1)) else $error("data count beyond capacity");
   a_rc_bound: assert property (@(posedge clock) disable iff (reset)
      rc_ff <= CW'(STACK_DEPTH - 1)) else $error("return count beyond capacity");
   a_no_rsp_clear: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !rsp_valid_ff) else $error("result during memory clear");
   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      halted_ff |=> halted_ff) else $error("halt flag dropped");

endmodule

// ===== rtl/stack_vm_instruction_executor.sv =====
`timescale 1ns / 1ps
// Stack machine instruction executor.
// Input channel req_*: one item per instruction or data memory preload, taken
// when req_valid is high and req_stall is low. Result channel rsp_*: exactly
// one item per input item, in order, held while rsp_stall is high.
// A front part decodes items into a two-entry queue; the back part runs each
// item through its states in order: stack reads in R1, R2 and R3, the operand
// and memory read in R4, execute, the one-bit-per-cycle divider for divide,
// stack writes in W1 and W2, and DONE, which hands the result to the output
// register and waits while the result held there is not yet taken. The single
// read port of each stack memory is why the stack reads are separate states.
// The back part takes no new item from the queue until it leaves DONE.
// After reset the block clears data memory, one word per cycle, through all
// MEM_DEPTH words; req_stall stays high during that time. Stacks, pointer,
// flags and halt are cleared at once. While rsp_stall holds a result, the
// queue still fills; req_stall rises once it is full.
module stack_vm_instruction_executor #(
   parameter int unsigned STACK_DEPTH = 1024,
   parameter int unsigned MEM_DEPTH   = 4096
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  svie_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output svie_pkg::rsp_type rsp_data
);

   logic                q_full, q_push, q_pop, q_empty, clearing;
   svie_pkg::entry_type q_in, q_out;

   svie_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .clearing (clearing),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_data   (q_in)
   );

   svie_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_data(q_in),
      .full     (q_full),
      .pop      (q_pop),
      .pop_data (q_out),
      .empty    (q_empty)
   );

   svie_back #(
      .STACK_DEPTH(STACK_DEPTH),
      .MEM_DEPTH  (MEM_DEPTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (q_empty),
      .q_pop    (q_pop),
      .q_data   (q_out),
      .clearing (clearing),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

endmodule
